// ----- design/u16u8_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u16u8_pkg: shared types and constants
// Payload structs, result codes and the job format passed from the front end
// to the byte serializer of the UTF-16 to UTF-8 name sanitizer.
// ----------------------------------------------------------------------------
package u16u8_pkg;

   localparam int CAP_W       = 13;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int JOB_BYTES   = 6;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

   localparam logic MODE_UNIT = 1'b0;
   localparam logic MODE_END  = 1'b1;

   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
   localparam logic [1:0] STATUS_RESERVED = 2'd2;

   localparam logic [15:0] HIGH_FIRST = 16'hd800;
   localparam logic [15:0] HIGH_LAST  = 16'hdbff;
   localparam logic [15:0] LOW_FIRST  = 16'hdc00;
   localparam logic [15:0] LOW_LAST   = 16'hdfff;
   localparam logic [20:0] SUPP_BASE  = 21'h10000;

   localparam logic [20:0] CP_SLASH      = 21'h2f;
   localparam logic [20:0] CP_BACKSLASH  = 21'h5c;
   localparam logic [20:0] CP_FIRST_PRINT = 21'h20;
   localparam logic [20:0] CP_UNDERSCORE = 21'h5f;
   localparam logic [20:0] CP_DOT        = 21'h2e;
   localparam logic [20:0] CP_MAX_1BYTE  = 21'h7f;
   localparam logic [20:0] CP_MAX_2BYTE  = 21'h7ff;
   localparam logic [20:0] CP_MAX_3BYTE  = 21'hffff;

   typedef struct packed {
      logic        mode;
      logic [15:0] code_unit;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       kind;
      logic [1:0] status;
      logic       last;
   } rsp_payload_type;

   // one input item's worth of results
   typedef struct packed {
      logic [JOB_BYTES-1:0][7:0] bytes;
      logic [2:0]                count;
      logic                      has_status;
      logic [1:0]                status;
   } job_type;

   typedef struct packed {
      logic [CAP_W-1:0] bytes_written;
      logic             overflowed;
      logic             all_dots;
   } str_state_type;

   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      n;
   } enc_type;

   typedef struct packed {
      str_state_type st;
      enc_type       enc;
   } emit_res_type;

endpackage
`default_nettype wire

// ----- design/u16u8_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u16u8_front: input classification and string state
// Accepts code units, pairs surrogates, sanitizes and encodes code points,
// applies the capacity check and queues a job for each item with a result.
// ----------------------------------------------------------------------------
module u16u8_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [u16u8_pkg::CAP_W-1:0]    csr_wdata,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire u16u8_pkg::req_payload_type     req_payload,
   input  wire logic                           queue_full,
   output logic                                push,
   output u16u8_pkg::job_type                  push_job
);

   logic [u16u8_pkg::CAP_W-1:0] cap_ff, cap_in;
   logic [15:0]                 pending_high_ff, pending_high_in;
   logic                        pending_valid_ff, pending_valid_in;
   u16u8_pkg::str_state_type    str_ff, str_in;

   logic                        accept;
   logic                        is_end, is_high, is_low, join_pair;
   logic                        a_en, b_en;
   logic [20:0]                 a_cp, b_cp;
   u16u8_pkg::emit_res_type     res_a, res_b;
   u16u8_pkg::job_type          job;
   logic [2:0]                  rel;

   function automatic u16u8_pkg::enc_type encode(input logic [20:0] cp);
      u16u8_pkg::enc_type e;
      e.bytes = '0;
      if (cp <= u16u8_pkg::CP_MAX_1BYTE) begin
         e.bytes[0] = cp[7:0];
         e.n        = 3'd1;
      end else if (cp <= u16u8_pkg::CP_MAX_2BYTE) begin
         e.bytes[0] = {3'b110, cp[10:6]};
         e.bytes[1] = {2'b10, cp[5:0]};
         e.n        = 3'd2;
      end else if (cp <= u16u8_pkg::CP_MAX_3BYTE) begin
         e.bytes[0] = {4'b1110, cp[15:12]};
         e.bytes[1] = {2'b10, cp[11:6]};
         e.bytes[2] = {2'b10, cp[5:0]};
         e.n        = 3'd3;
      end else begin
         e.bytes[0] = {5'b11110, cp[20:18]};
         e.bytes[1] = {2'b10, cp[17:12]};
         e.bytes[2] = {2'b10, cp[11:6]};
         e.bytes[3] = {2'b10, cp[5:0]};
         e.n        = 3'd4;
      end
      return e;
   endfunction

   // one code point against the string state; n is zero when dropped
   function automatic u16u8_pkg::emit_res_type emit_cp(
      input u16u8_pkg::str_state_type     st,
      input logic [u16u8_pkg::CAP_W-1:0]  cap,
      input logic [20:0]                  cp_raw,
      input logic                         en
   );
      u16u8_pkg::emit_res_type r;
      logic [20:0]             cp;
      logic [u16u8_pkg::CAP_W:0] need;
      cp = cp_raw;
      if (cp == u16u8_pkg::CP_SLASH || cp == u16u8_pkg::CP_BACKSLASH ||
          cp < u16u8_pkg::CP_FIRST_PRINT) begin
         cp = u16u8_pkg::CP_UNDERSCORE;
      end
      r.st  = st;
      r.enc = encode(cp);
      need  = {1'b0, st.bytes_written} + (u16u8_pkg::CAP_W+1)'(r.enc.n) +
              (u16u8_pkg::CAP_W+1)'(1);
      if (!en || st.overflowed) begin
         r.enc.n = 3'd0;
      end else if (need > {1'b0, cap}) begin
         r.st.overflowed = 1'b1;
         r.enc.n         = 3'd0;
      end else begin
         if (cp != u16u8_pkg::CP_DOT) begin
            r.st.all_dots = 1'b0;
         end
         r.st.bytes_written = st.bytes_written + u16u8_pkg::CAP_W'(r.enc.n);
      end
      return r;
   endfunction

   assign csr_ready = 1'b1;
   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      is_end    = req_payload.mode == u16u8_pkg::MODE_END;
      is_high   = req_payload.code_unit >= u16u8_pkg::HIGH_FIRST &&
                  req_payload.code_unit <= u16u8_pkg::HIGH_LAST;
      is_low    = req_payload.code_unit >= u16u8_pkg::LOW_FIRST &&
                  req_payload.code_unit <= u16u8_pkg::LOW_LAST;
      join_pair = !is_end && pending_valid_ff && is_low;

      a_en = pending_valid_ff;
      if (join_pair) begin
         a_cp = u16u8_pkg::SUPP_BASE +
                {1'b0, pending_high_ff[9:0], req_payload.code_unit[9:0]};
      end else begin
         a_cp = {5'd0, pending_high_ff};
      end
      b_en = !is_end && !join_pair && !is_high;
      b_cp = {5'd0, req_payload.code_unit};
   end

   always_comb begin
      res_a = emit_cp(str_ff, cap_ff, a_cp, a_en);
      res_b = emit_cp(res_a.st, cap_ff, b_cp, b_en);
   end

   always_comb begin
      job.count      = res_a.enc.n + res_b.enc.n;
      job.has_status = is_end;
      job.status     = u16u8_pkg::STATUS_OK;
      rel            = 3'd0;
      for (int k = 0; k < u16u8_pkg::JOB_BYTES; k++) begin
         if (3'(k) < res_a.enc.n) begin
            job.bytes[k] = res_a.enc.bytes[2'(k)];
         end else begin
            rel          = 3'(k) - res_a.enc.n;
            job.bytes[k] = res_b.enc.bytes[rel[1:0]];
         end
      end
      if (res_a.st.overflowed ||
          ({1'b0, res_a.st.bytes_written} + (u16u8_pkg::CAP_W+1)'(1)) > {1'b0, cap_ff}) begin
         job.status = u16u8_pkg::STATUS_OVERFLOW;
      end else if (res_a.st.all_dots && (res_a.st.bytes_written == u16u8_pkg::CAP_W'(1) ||
                                         res_a.st.bytes_written == u16u8_pkg::CAP_W'(2))) begin
         job.status = u16u8_pkg::STATUS_RESERVED;
      end
   end

   assign push     = accept && (job.count != 3'd0 || job.has_status);
   assign push_job = job;

   always_comb begin
      cap_in           = csr_valid ? csr_wdata : cap_ff;
      pending_high_in  = pending_high_ff;
      pending_valid_in = pending_valid_ff;
      str_in           = str_ff;
      if (accept) begin
         if (is_end) begin
            pending_high_in  = '0;
            pending_valid_in = 1'b0;
            str_in           = '{bytes_written: '0, overflowed: 1'b0, all_dots: 1'b1};
         end else begin
            str_in = res_b.st;
            if (!join_pair && is_high) begin
               pending_high_in  = req_payload.code_unit;
               pending_valid_in = 1'b1;
            end else begin
               pending_high_in  = '0;
               pending_valid_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff           <= u16u8_pkg::CAP_RESET;
         pending_high_ff  <= '0;
         pending_valid_ff <= 1'b0;
         str_ff           <= '{bytes_written: '0, overflowed: 1'b0, all_dots: 1'b1};
      end else begin
         cap_ff           <= cap_in;
         pending_high_ff  <= pending_high_in;
         pending_valid_ff <= pending_valid_in;
         str_ff           <= str_in;
      end
   end

endmodule
`default_nettype wire

// ----- design/u16u8_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u16u8_queue: job queue
// Small first-in first-out buffer of jobs between the front end and the
// byte serializer.
// ----------------------------------------------------------------------------
module u16u8_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire u16u8_pkg::job_type   push_job,
   input  wire logic                 pop,
   output logic                      full,
   output logic                      empty,
   output u16u8_pkg::job_type        head_job
);

   u16u8_pkg::job_type                  entry_ff [u16u8_pkg::QUEUE_DEPTH];
   logic [u16u8_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [u16u8_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [u16u8_pkg::QCNT_W-1:0]        count_ff, count_in;

   assign full     = count_ff == u16u8_pkg::QCNT_W'(u16u8_pkg::QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign head_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// ----- design/u16u8_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u16u8_back: result serializer
// Walks the head job into the output register one result per cycle while the
// output is free: data bytes first, then any end-of-string status of the job.
// ----------------------------------------------------------------------------
module u16u8_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       head_empty,
   input  wire u16u8_pkg::job_type         head_job,
   output logic                            pop,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output u16u8_pkg::rsp_payload_type      rsp_payload
);

   logic [2:0]                  idx_ff, idx_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   u16u8_pkg::rsp_payload_type  rsp_payload_ff, rsp_payload_in;
   logic                        produce, is_data;

   assign produce = (!rsp_valid_ff || rsp_ready) && !head_empty;
   assign is_data = idx_ff < head_job.count;

   always_comb begin
      if (is_data) begin
         rsp_payload_in.out_byte = head_job.bytes[idx_ff];
         rsp_payload_in.kind     = u16u8_pkg::KIND_DATA;
         rsp_payload_in.status   = u16u8_pkg::STATUS_OK;
         rsp_payload_in.last     = (idx_ff == head_job.count - 3'd1) && !head_job.has_status;
      end else begin
         rsp_payload_in.out_byte = 8'd0;
         rsp_payload_in.kind     = u16u8_pkg::KIND_STATUS;
         rsp_payload_in.status   = head_job.status;
         rsp_payload_in.last     = 1'b1;
      end
   end

   assign pop = produce && rsp_payload_in.last;

   always_comb begin
      idx_in = idx_ff;
      if (pop) begin
         idx_in = 3'd0;
      end else if (produce) begin
         idx_in = idx_ff + 3'd1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (produce) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (produce) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef NO_ASSERTIONS
   a_status_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_payload_ff.kind == u16u8_pkg::KIND_STATUS |-> rsp_payload_ff.last)
      else $error("status item not marked last");

   a_data_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_payload_ff.kind == u16u8_pkg::KIND_DATA |->
      rsp_payload_ff.status == u16u8_pkg::STATUS_OK)
      else $error("data item carries a status");

   a_idx_in_job: assert property (@(posedge clock) disable iff (reset)
      !head_empty |-> idx_ff <= head_job.count)
      else $error("byte index ran past the head job");

   a_idx_idle_zero: assert property (@(posedge clock) disable iff (reset)
      head_empty |-> idx_ff == 3'd0)
      else $error("byte index not cleared with queue empty");
`endif

endmodule
`default_nettype wire

// ----- design/utf16_to_utf8_name_sanitizer_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// utf16_to_utf8_name_sanitizer_core: UTF-16 file name to UTF-8 converter
// Top level: front end, job queue and result serializer.
// ----------------------------------------------------------------------------
// The input side takes one code unit or end mark per clock while the four-job
// queue has room; a held high surrogate produces no result. The output side
// delivers one result per clock while the receiver is ready; an item that
// yields N bytes, N at most six, gives N data results (plus one status result
// for an end mark); a BMP character takes up to three. Sustained throughput
// is set by the single-byte output register. The first result of an item is
// written into a queue entry and then into the output register before it is
// presented. Writes on the csr port set the output capacity and take effect
// on the next item.
module utf16_to_utf8_name_sanitizer_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [u16u8_pkg::CAP_W-1:0]    csr_wdata,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire u16u8_pkg::req_payload_type     req_payload,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output u16u8_pkg::rsp_payload_type          rsp_payload
);

   logic                 push, pop, full, empty;
   u16u8_pkg::job_type   push_job, head_job;

   u16u8_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .queue_full  (full),
      .push        (push),
      .push_job    (push_job)
   );

   u16u8_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .full     (full),
      .empty    (empty),
      .head_job (head_job)
   );

   u16u8_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_empty  (empty),
      .head_job    (head_job),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

// ----- verif/utf8_name_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_name_checker: result predictor and comparator for the name sanitizer
// Watches the configuration, request and response channels, keeps its own
// copy of the string state, predicts the UTF-8 bytes and end status of each
// accepted item, and compares every accepted response with the oldest one.
// ----------------------------------------------------------------------------
module utf8_name_checker
   import u16u8_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_valid,
   input  wire logic             csr_ready,
   input  wire logic [CAP_W-1:0] csr_wdata,
   input  wire logic             req_valid,
   input  wire logic             req_ready,
   input  wire req_payload_type  req_payload,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_ready,
   input  wire rsp_payload_type  rsp_payload,
   output int unsigned           mismatch_count,
   output int unsigned           pending_count,
   output int unsigned           checked_count,
   output int unsigned           overflow_count,
   output int unsigned           reserved_count
);

   logic [CAP_W-1:0] capacity;
   logic [15:0]      held_high;
   logic             held_valid;
   int unsigned      str_bytes;
   logic             name_overflow;
   logic             name_dots;

   rsp_payload_type  utf8_expected[$];
   rsp_payload_type  item_res[$];

   function automatic void clear_name();
      held_high     = '0;
      held_valid    = 1'b0;
      str_bytes     = 0;
      name_overflow = 1'b0;
      name_dots     = 1'b1;
   endfunction

   function automatic void add_result(logic [7:0] value, logic kind, logic [1:0] status);
      rsp_payload_type r;
      r.out_byte = value;
      r.kind     = kind;
      r.status   = status;
      r.last     = 1'b0;
      item_res.push_back(r);
   endfunction

   function automatic void encode_char(int unsigned cp_in);
      int unsigned cp;
      logic [7:0]  b [4];
      int unsigned n;
      int unsigned k;
      cp = cp_in;
      if (cp == CP_SLASH || cp == CP_BACKSLASH || cp < CP_FIRST_PRINT) begin
         cp = CP_UNDERSCORE;
      end
      if (cp <= CP_MAX_1BYTE) begin
         b[0] = 8'(cp);
         n    = 1;
      end else if (cp <= CP_MAX_2BYTE) begin
         b[0] = 8'(32'hc0 | (cp >> 6));
         b[1] = 8'(32'h80 | (cp & 32'h3f));
         n    = 2;
      end else if (cp <= CP_MAX_3BYTE) begin
         b[0] = 8'(32'he0 | (cp >> 12));
         b[1] = 8'(32'h80 | ((cp >> 6) & 32'h3f));
         b[2] = 8'(32'h80 | (cp & 32'h3f));
         n    = 3;
      end else begin
         b[0] = 8'(32'hf0 | ((cp >> 18) & 32'h07));
         b[1] = 8'(32'h80 | ((cp >> 12) & 32'h3f));
         b[2] = 8'(32'h80 | ((cp >> 6) & 32'h3f));
         b[3] = 8'(32'h80 | (cp & 32'h3f));
         n    = 4;
      end
      if (name_overflow) return;
      // whole character dropped when it and the terminating zero do not fit
      if (str_bytes + n + 1 > capacity) begin
         name_overflow = 1'b1;
         return;
      end
      if (cp != CP_DOT) name_dots = 1'b0;
      for (k = 0; k < n; k++) add_result(b[k], KIND_DATA, STATUS_OK);
      str_bytes += n;
   endfunction

   function automatic void predict_item(req_payload_type p);
      logic [1:0]      st;
      int unsigned     pair_cp;
      int unsigned     i;
      rsp_payload_type r;
      item_res.delete();
      if (p.mode == MODE_END) begin
         if (held_valid) encode_char(held_high);
         if (name_overflow || str_bytes + 1 > capacity) begin
            st = STATUS_OVERFLOW;
         end else if (name_dots && (str_bytes == 1 || str_bytes == 2)) begin
            st = STATUS_RESERVED;
         end else begin
            st = STATUS_OK;
         end
         add_result(8'h00, KIND_STATUS, st);
         clear_name();
      end else if (held_valid && p.code_unit >= LOW_FIRST && p.code_unit <= LOW_LAST) begin
         pair_cp = 32'(SUPP_BASE) + ((32'(held_high) - 32'(HIGH_FIRST)) << 10)
                   + (32'(p.code_unit) - 32'(LOW_FIRST));
         encode_char(pair_cp);
         held_valid = 1'b0;
         held_high  = '0;
      end else begin
         // a held high surrogate without its low half goes out on its own
         if (held_valid) begin
            encode_char(held_high);
            held_valid = 1'b0;
            held_high  = '0;
         end
         if (p.code_unit >= HIGH_FIRST && p.code_unit <= HIGH_LAST) begin
            held_high  = p.code_unit;
            held_valid = 1'b1;
         end else begin
            encode_char(p.code_unit);
         end
      end
      for (i = 0; i < item_res.size(); i++) begin
         r      = item_res[i];
         r.last = (i == item_res.size() - 1);
         utf8_expected.push_back(r);
      end
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         capacity = CAP_RESET;
         clear_name();
         utf8_expected.delete();
         mismatch_count <= 0;
         checked_count  <= 0;
         overflow_count <= 0;
         reserved_count <= 0;
      end else begin
         if (csr_valid && csr_ready) capacity = csr_wdata;
         if (req_valid && req_ready) predict_item(req_payload);
         if (rsp_valid && rsp_ready) begin
            checked_count <= checked_count + 1;
            if (rsp_payload.kind == KIND_STATUS && rsp_payload.status == STATUS_OVERFLOW) begin
               overflow_count <= overflow_count + 1;
            end
            if (rsp_payload.kind == KIND_STATUS && rsp_payload.status == STATUS_RESERVED) begin
               reserved_count <= reserved_count + 1;
            end
            if (utf8_expected.size() == 0) begin
               $display("%0t: unexpected result, expected none, got byte %h kind %0d status %0d",
                        $time, rsp_payload.out_byte, rsp_payload.kind, rsp_payload.status);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = utf8_expected.pop_front();
               if (rsp_payload.out_byte !== want.out_byte || rsp_payload.kind !== want.kind ||
                   rsp_payload.status !== want.status || rsp_payload.last !== want.last) begin
                  $display("%0t: byte/kind/status/last expected %h/%0d/%0d/%0d, got %h/%0d/%0d/%0d",
                           $time, want.out_byte, want.kind, want.status, want.last,
                           rsp_payload.out_byte, rsp_payload.kind, rsp_payload.status,
                           rsp_payload.last);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
      end
      pending_count <= utf8_expected.size();
   end

endmodule

// ----- verif/tb_utf16_to_utf8_name_sanitizer_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_utf16_to_utf8_name_sanitizer_core: testbench for the name sanitizer
// Sends directed code units and end marks, then random file names in phases
// with different output capacities and idling patterns, including a long
// receiver hold-off. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_utf16_to_utf8_name_sanitizer_core;
   import u16u8_pkg::*;

   localparam int CLOCK_HALF     = 5;
   localparam int RESET_CYCLES   = 6;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 300;
   localparam int SETTLE_CYCLES  = 8;
   localparam int NUM_PHASES     = 8;
   localparam int PHASE_ITEMS    = 42;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             csr_valid   = 1'b0;
   logic [CAP_W-1:0] csr_wdata   = '0;
   logic             req_valid   = 1'b0;
   req_payload_type  req_payload = '0;
   logic             rsp_ready   = 1'b0;
   logic             csr_ready;
   logic             req_ready;
   logic             rsp_valid;
   rsp_payload_type  rsp_payload;

   int unsigned mismatch_count;
   int unsigned pending_count;
   int unsigned checked_count;
   int unsigned overflow_count;
   int unsigned reserved_count;

   int unsigned req_idle_pct  = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned hold_gen      = 0;
   int unsigned hold_seen     = 0;
   int unsigned hold_left     = 0;
   int unsigned idle_cycles   = 0;
   int unsigned items_sent    = 0;
   int unsigned names_sent    = 0;

   utf16_to_utf8_name_sanitizer_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   utf8_name_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_payload    (rsp_payload),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count),
      .overflow_count (overflow_count),
      .reserved_count (reserved_count)
   );

   always begin
      #(CLOCK_HALF) clock = 1'b1;
      #(CLOCK_HALF) clock = 1'b0;
   end

   // receiver: random stalls, or a long hold-off whenever hold_gen moves on
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_seen != hold_gen) begin
         hold_seen <= hold_gen;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   task automatic send_item(input logic mode, input logic [15:0] code_val);
      req_payload_type p;
      p.mode      = mode;
      p.code_unit = code_val;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic end_name();
      send_item(MODE_END, 16'($urandom));
      names_sent++;
   endtask

   // stop sending until every predicted result is out, then let the block settle
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      drain_results();
      csr_valid <= 1'b1;
      csr_wdata <= cap;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_char();
      int unsigned sel;
      int unsigned val;
      sel = $urandom_range(99);
      if (sel < 20) begin
         send_item(MODE_UNIT, 16'($urandom_range(16'h20, 16'h7e)));
      end else if (sel < 30) begin
         send_item(MODE_UNIT, 16'(CP_DOT));
      end else if (sel < 38) begin
         case ($urandom_range(3))
            0: val = CP_SLASH;
            1: val = CP_BACKSLASH;
            2: val = CP_MAX_1BYTE;
            default: val = $urandom_range(31);
         endcase
         send_item(MODE_UNIT, 16'(val));
      end else if (sel < 52) begin
         send_item(MODE_UNIT, 16'($urandom_range(16'h80, 16'h7ff)));
      end else if (sel < 66) begin
         // BMP outside the surrogate range
         val = $urandom_range(16'h800, 16'hf7ff);
         if (val >= HIGH_FIRST) val += 16'h800;
         send_item(MODE_UNIT, 16'(val));
      end else if (sel < 84) begin
         send_item(MODE_UNIT, 16'($urandom_range(HIGH_FIRST, HIGH_LAST)));
         send_item(MODE_UNIT, 16'($urandom_range(LOW_FIRST, LOW_LAST)));
      end else if (sel < 90) begin
         send_item(MODE_UNIT, 16'($urandom_range(HIGH_FIRST, LOW_LAST)));
      end else begin
         send_item(MODE_UNIT, 16'($urandom));
      end
   endtask

   task automatic send_name(input int unsigned len);
      int unsigned i;
      for (i = 0; i < len; i++) send_char();
      end_name();
   endtask

   initial begin
      int unsigned phase;
      int unsigned phase_start;
      int unsigned sel;
      int unsigned i;
      logic [CAP_W-1:0] cap;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: one item per encoding edge, surrogate cases and dot names
      send_item(MODE_UNIT, 16'h0061);
      send_item(MODE_UNIT, 16'h0000);
      send_item(MODE_UNIT, 16'h001f);
      send_item(MODE_UNIT, 16'(CP_SLASH));
      send_item(MODE_UNIT, 16'(CP_BACKSLASH));
      send_item(MODE_UNIT, 16'h007f);
      send_item(MODE_UNIT, 16'h0080);
      send_item(MODE_UNIT, 16'h07ff);
      send_item(MODE_UNIT, 16'h0800);
      send_item(MODE_UNIT, 16'hffff);
      send_item(MODE_UNIT, HIGH_FIRST);
      send_item(MODE_UNIT, LOW_FIRST);
      send_item(MODE_UNIT, HIGH_LAST);
      send_item(MODE_UNIT, LOW_LAST);
      // lone low, then a high surrogate cut short by a plain character
      send_item(MODE_UNIT, LOW_FIRST);
      send_item(MODE_UNIT, 16'hd83d);
      send_item(MODE_UNIT, 16'h0041);
      // high surrogate still held at the end mark
      send_item(MODE_UNIT, HIGH_FIRST);
      end_name();
      send_item(MODE_UNIT, 16'(CP_DOT));
      end_name();
      send_item(MODE_UNIT, 16'(CP_DOT));
      send_item(MODE_UNIT, 16'(CP_DOT));
      end_name();
      end_name();

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: cap = 13'd4096;
            1: cap = 13'd1;
            2: cap = 13'd0;
            3: cap = 13'd8191;
            4: cap = CAP_RESET;
            5: cap = 13'd6;
            6: cap = 13'($urandom_range(2, 24));
            default: cap = 13'($urandom_range(1, 4096));
         endcase
         write_capacity(cap);
         case (phase % 4)
            0: begin
               req_idle_pct  = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               req_idle_pct  = 77;
               rsp_stall_pct = 0;
            end
            2: begin
               req_idle_pct  = 0;
               rsp_stall_pct = 77;
            end
            default: begin
               req_idle_pct  = 7;
               rsp_stall_pct = 7;
            end
         endcase
         // receiver holds off while the sender keeps offering items
         if (phase == 4) hold_gen <= hold_gen + 1;
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            sel = $urandom_range(99);
            if (sel < 12) begin
               for (i = $urandom_range(1, 3); i > 0; i--) send_item(MODE_UNIT, 16'(CP_DOT));
               end_name();
            end else if (sel < 70) begin
               send_name($urandom_range(0, 6));
            end else if (sel < 95) begin
               send_name($urandom_range(7, 20));
            end else begin
               send_name($urandom_range(21, 48));
            end
         end
      end

      drain_results();
      $display("Summary: %0d items in %0d names, %0d results checked, %0d overflow and %0d %s",
               items_sent, names_sent, checked_count, overflow_count, reserved_count,
               "reserved-name statuses");
      $display("Summary: capacities 0 to 8191, idle-free, sender-idle, receiver-stall, %s",
               "mixed and long hold-off phases");
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
design/u16u8_pkg.sv
design/u16u8_front.sv
design/u16u8_queue.sv
design/u16u8_back.sv
design/utf16_to_utf8_name_sanitizer_core.sv
verif/utf8_name_checker.sv
verif/tb_utf16_to_utf8_name_sanitizer_core.sv
